### sv/svrp_pkg.sv
// Shared constants for the stepper velocity ramp and prescaler block.
// Holds field widths, register reset values, op codes and register indexes.
// No dependencies.
package svrp_pkg;

   localparam int VELOCITY_WIDTH_DEFAULT = 24;
   localparam int STEP_WIDTH             = 23;
   localparam int FREQ_WIDTH             = 32;
   localparam int PRESCALER_WIDTH        = 16;
   localparam int SPEED_WIDTH            = 24;
   localparam int CSR_DATA_WIDTH         = 32;
   localparam int CSR_INDEX_WIDTH        = 2;
   localparam int OP_WIDTH               = 2;

   localparam logic [OP_WIDTH-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SET     = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_ENABLE  = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_DISABLE = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] IDX_MAX_STEP = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] IDX_FREQ     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] IDX_MIN_PRE  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] IDX_MAX_PRE  = 2'd3;

   localparam logic [STEP_WIDTH-1:0]      MAX_STEP_RESET = 23'd100;
   localparam logic [FREQ_WIDTH-1:0]      FREQ_RESET     = 32'd1000000;
   localparam logic [PRESCALER_WIDTH-1:0] MIN_PRE_RESET  = 16'd1;
   localparam logic [PRESCALER_WIDTH-1:0] MAX_PRE_RESET  = 16'd65535;

endpackage

### sv/svrp_if.sv
// Valid/ready channel interfaces for the ramp block: command words in,
// status words out. Depends on svrp_pkg.
interface svrp_req_if #(
   parameter int VELOCITY_WIDTH = svrp_pkg::VELOCITY_WIDTH_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic [svrp_pkg::OP_WIDTH-1:0]        op;
   logic signed [VELOCITY_WIDTH-1:0]     target_velocity;

   modport source (output valid, op, target_velocity, input ready);
   modport sink   (input valid, op, target_velocity, output ready);
endinterface

interface svrp_rsp_if #(
   parameter int VELOCITY_WIDTH = svrp_pkg::VELOCITY_WIDTH_DEFAULT
);
   logic                                   valid;
   logic                                   ready;
   logic signed [VELOCITY_WIDTH-1:0]       velocity;
   logic [svrp_pkg::SPEED_WIDTH-1:0]       speed;
   logic                                   direction;
   logic [svrp_pkg::PRESCALER_WIDTH-1:0]   prescaler;
   logic                                   enabled;

   modport source (output valid, velocity, speed, direction, prescaler, enabled,
                   input ready);
   modport sink   (input valid, velocity, speed, direction, prescaler, enabled,
                   output ready);
endinterface

### sv/svrp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Timer frequency over speed for the prescaler. Depends on svrp_pkg.
module svrp_div #(
   parameter int DIVISOR_WIDTH = svrp_pkg::VELOCITY_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [svrp_pkg::FREQ_WIDTH-1:0]   dividend,
   input  logic [DIVISOR_WIDTH-1:0]          divisor,
   output logic                              done,
   output logic [svrp_pkg::FREQ_WIDTH-1:0]   quotient
);
   localparam int QW = svrp_pkg::FREQ_WIDTH;
   localparam int CW = $clog2(QW);
   localparam logic [CW-1:0] LAST = CW'(QW - 1);

   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [QW-1:0]            quo_ff, quo_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [DIVISOR_WIDTH:0]   shifted;
   logic [DIVISOR_WIDTH+1:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[QW-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // trial subtract; keep it when no borrow
         if (!diff[DIVISOR_WIDTH+1]) begin
            rem_in = diff[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/stepper_velocity_ramp_prescaler.sv
// Top level of the stepper velocity ramp with timer prescaler.
// Depends on svrp_pkg, svrp_if (channel interfaces) and svrp_div.
//
// Usage:
//   req_chan takes command words: tick, set target, enable, disable.
//   rsp_chan returns one status word per command: velocity, speed,
//   direction, prescaler and enabled flag after that command.
//   csr_wr_en/csr_index/csr_wr_data write the max step, timer frequency
//   and prescaler limits; write them only while no command is in flight.
// Sequence:
//   An enabled tick runs a slew pass, the speed step, the 32 one-bit
//   steps of the divider, the clamp step and a second slew pass.
//   A tick at zero speed skips the divider; a disabled tick and the
//   other commands go straight to the done step.
//   One command is worked on at a time; req_chan.ready is high while idle.
// Reset (synchronous, active high) clears velocity, goal, speed, direction
// and enable, sets the prescaler to 65535 and the registers to defaults.
// A stalled rsp_chan holds its word; the next command is still accepted
// and its result waits until the output register frees up.
module stepper_velocity_ramp_prescaler #(
   parameter int VELOCITY_WIDTH = svrp_pkg::VELOCITY_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [svrp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [svrp_pkg::CSR_DATA_WIDTH-1:0]   csr_wr_data,
   svrp_req_if.sink                              req_chan,
   svrp_rsp_if.source                            rsp_chan
);
   localparam int W   = VELOCITY_WIDTH;
   localparam int SW  = svrp_pkg::STEP_WIDTH;
   localparam int PW  = svrp_pkg::PRESCALER_WIDTH;
   localparam int FW  = svrp_pkg::FREQ_WIDTH;
   localparam int SPW = svrp_pkg::SPEED_WIDTH;
   // error width: goal - now, and room for the step compare
   localparam int DW  = (W + 1 > SW + 1) ? W + 2 : SW + 2;

   typedef enum logic [6:0] {
      S_IDLE       = 7'b0000001,
      S_SLEW_ERR   = 7'b0000010,
      S_SLEW_APPLY = 7'b0000100,
      S_SPEED      = 7'b0001000,
      S_DIV        = 7'b0010000,
      S_CLAMP      = 7'b0100000,
      S_DONE       = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0] max_step_ff, max_step_in;
   logic [FW-1:0] freq_ff, freq_in;
   logic [PW-1:0] min_pre_ff, min_pre_in;
   logic [PW-1:0] max_pre_ff, max_pre_in;

   logic signed [W-1:0]  velocity_now_ff, velocity_now_in;
   logic signed [W-1:0]  velocity_goal_ff, velocity_goal_in;
   logic [W-1:0]         speed_now_ff, speed_now_in;
   logic                 turn_forward_ff, turn_forward_in;
   logic                 run_enabled_ff, run_enabled_in;
   logic [PW-1:0]        prescaler_now_ff, prescaler_now_in;
   logic                 second_ff, second_in;
   logic signed [DW-1:0] err_ff, err_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]  rsp_velocity_ff;
   logic [SPW-1:0]       rsp_speed_ff;
   logic                 rsp_direction_ff;
   logic [PW-1:0]        rsp_prescaler_ff;
   logic                 rsp_enabled_ff;
   logic                 load_rsp;

   logic signed [DW-1:0] step_ext;
   logic signed [DW-1:0] slew_up, slew_down;
   logic [W-1:0]         speed_mag;
   logic                 div_start;
   logic                 div_done;
   logic [FW-1:0]        div_quotient;

   svrp_div #(.DIVISOR_WIDTH(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (freq_ff),
      .divisor  (speed_now_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      step_ext  = DW'(max_step_ff);
      slew_up   = DW'(velocity_now_ff) + step_ext;
      slew_down = DW'(velocity_now_ff) - step_ext;
      speed_mag = velocity_now_ff[W-1] ? (~velocity_now_ff + 1'b1) : velocity_now_ff;

      state_in         = state_ff;
      max_step_in      = max_step_ff;
      freq_in          = freq_ff;
      min_pre_in       = min_pre_ff;
      max_pre_in       = max_pre_ff;
      velocity_now_in  = velocity_now_ff;
      velocity_goal_in = velocity_goal_ff;
      speed_now_in     = speed_now_ff;
      turn_forward_in  = turn_forward_ff;
      run_enabled_in   = run_enabled_ff;
      prescaler_now_in = prescaler_now_ff;
      second_in        = second_ff;
      err_in           = err_ff;
      div_start        = 1'b0;
      load_rsp         = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            svrp_pkg::IDX_MAX_STEP: max_step_in = csr_wr_data[SW-1:0];
            svrp_pkg::IDX_FREQ:     freq_in     = csr_wr_data[FW-1:0];
            svrp_pkg::IDX_MIN_PRE:  min_pre_in  = csr_wr_data[PW-1:0];
            svrp_pkg::IDX_MAX_PRE:  max_pre_in  = csr_wr_data[PW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_DONE;
               case (req_chan.op)
                  svrp_pkg::OP_TICK: begin
                     if (run_enabled_ff) begin
                        state_in  = S_SLEW_ERR;
                        second_in = 1'b0;
                     end
                  end
                  svrp_pkg::OP_SET: velocity_goal_in = req_chan.target_velocity;
                  svrp_pkg::OP_ENABLE: begin
                     run_enabled_in   = 1'b1;
                     velocity_goal_in = '0;
                     velocity_now_in  = '0;
                     speed_now_in     = '0;
                  end
                  default: run_enabled_in = 1'b0;
               endcase
            end
         end
         S_SLEW_ERR: begin
            err_in   = DW'(velocity_goal_ff) - DW'(velocity_now_ff);
            state_in = S_SLEW_APPLY;
         end
         S_SLEW_APPLY: begin
            if (err_ff > step_ext) begin
               velocity_now_in = slew_up[W-1:0];
            end else if (err_ff < -step_ext) begin
               velocity_now_in = slew_down[W-1:0];
            end else begin
               velocity_now_in = velocity_goal_ff;
            end
            state_in = second_ff ? S_DONE : S_SPEED;
         end
         S_SPEED: begin
            if (velocity_now_ff == '0) begin
               // zero speed: direction holds, prescaler at its ceiling
               speed_now_in     = '0;
               prescaler_now_in = max_pre_ff;
               second_in        = 1'b1;
               state_in         = S_SLEW_ERR;
            end else begin
               speed_now_in    = speed_mag;
               turn_forward_in = !velocity_now_ff[W-1];
               div_start       = 1'b1;
               state_in        = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            // crossed limits: a quotient above the upper limit takes it, any other takes the lower
            if (div_quotient > FW'(max_pre_ff)) begin
               prescaler_now_in = max_pre_ff;
            end else if (div_quotient < FW'(min_pre_ff)) begin
               prescaler_now_in = min_pre_ff;
            end else begin
               prescaler_now_in = div_quotient[PW-1:0];
            end
            second_in = 1'b1;
            state_in  = S_SLEW_ERR;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         max_step_ff      <= svrp_pkg::MAX_STEP_RESET;
         freq_ff          <= svrp_pkg::FREQ_RESET;
         min_pre_ff       <= svrp_pkg::MIN_PRE_RESET;
         max_pre_ff       <= svrp_pkg::MAX_PRE_RESET;
         velocity_now_ff  <= '0;
         velocity_goal_ff <= '0;
         speed_now_ff     <= '0;
         turn_forward_ff  <= 1'b0;
         run_enabled_ff   <= 1'b0;
         prescaler_now_ff <= svrp_pkg::MAX_PRE_RESET;
         second_ff        <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         max_step_ff      <= max_step_in;
         freq_ff          <= freq_in;
         min_pre_ff       <= min_pre_in;
         max_pre_ff       <= max_pre_in;
         velocity_now_ff  <= velocity_now_in;
         velocity_goal_ff <= velocity_goal_in;
         speed_now_ff     <= speed_now_in;
         turn_forward_ff  <= turn_forward_in;
         run_enabled_ff   <= run_enabled_in;
         prescaler_now_ff <= prescaler_now_in;
         second_ff        <= second_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      if (load_rsp) begin
         rsp_velocity_ff  <= velocity_now_ff;
         rsp_speed_ff     <= SPW'(speed_now_ff);
         rsp_direction_ff <= turn_forward_ff;
         rsp_prescaler_ff <= prescaler_now_ff;
         rsp_enabled_ff   <= run_enabled_ff;
      end
   end

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.velocity  = rsp_velocity_ff;
   assign rsp_chan.speed     = rsp_speed_ff;
   assign rsp_chan.direction = rsp_direction_ff;
   assign rsp_chan.prescaler = rsp_prescaler_ff;
   assign rsp_chan.enabled   = rsp_enabled_ff;

`ifndef SYNTHESIS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> speed_mag != '0)
      else $error("divider started with zero speed");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished while sequencer not waiting");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("status word raised outside done state");

   a_enable_clears: assert property (@(posedge clock) disable iff (reset)
      $rose(run_enabled_ff) |->
         velocity_now_ff == '0 && velocity_goal_ff == '0 && speed_now_ff == '0)
      else $error("enable did not clear the ramp state");
`endif

endmodule
